// ===== rtl/mpws_pkg.sv =====
// Shared definitions for the max pooling window stream block.
// Holds the register index codes, register field widths and the clamp helper.
// No dependencies.
package mpws_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;

    // Widths of the register fields as they are written.
    localparam int IMAGE_WIDTH_BITS   = 10;
    localparam int IMAGE_HEIGHT_BITS  = 10;
    localparam int CHANNEL_COUNT_BITS = 5;
    localparam int WINDOW_WIDTH_BITS  = 5;
    localparam int WINDOW_HEIGHT_BITS = 5;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_WINDOW_WIDTH  = 3'd3,
        CFG_WINDOW_HEIGHT = 3'd4
    } t_cfg_reg;

    // Effective register value minus one: zero acts as one, and a value above
    // the limit acts as the limit.
    function automatic int unsigned clamp_m1(input int unsigned value, input int unsigned limit);
        int unsigned res;
        if (value == 0) begin
            res = 0;
        end else if (value > limit) begin
            res = limit - 1;
        end else begin
            res = value - 1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/mpws_if.sv =====
// Handshake interfaces for the max pooling window stream block.
// Sample channel, pooled result channel and configuration write channel.
// Depends on mpws_pkg for the configuration port widths.
interface mpws_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mpws_result_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_BITS    = 9,
    parameter int ROW_BITS    = 9,
    parameter int CHAN_BITS   = 4
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled;
    logic        [COL_BITS-1:0]    out_col;
    logic        [ROW_BITS-1:0]    out_row;
    logic        [CHAN_BITS-1:0]   channel;
    logic                          image_done;

    modport source (output valid, output pooled, output out_col, output out_row,
                    output channel, output image_done, input ready);
    modport sink   (input valid, input pooled, input out_col, input out_row,
                    input channel, input image_done, output ready);
endinterface

interface mpws_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mpws_pkg::CFG_INDEX_BITS-1:0] index;
    logic [mpws_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/max_pool_window_stream_top.sv =====
// Non-overlapping 2-D max pooling over a raster-order sample stream.
// The store does one read and one write a cycle; each result passes the update stage,
// then the output register. Throughput: one sample per cycle unless the output stalls.
// Reset (synchronous, active low) clears the position counters and valid flags and
// loads the register defaults; stored maxima are not cleared and need no clearing pass.
module max_pool_window_stream_top #(
    parameter int MAX_WIDTH    = 512,
    parameter int MAX_HEIGHT   = 512,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mpws_cfg_if.sink      i_cfg,
    mpws_sample_if.sink   i_in,
    mpws_result_if.source o_out
);

    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CHAN_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WIN_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIN_RST   = (MAX_WINDOW >= 2) ? 1 : 0;

    // Effective register values, each kept as value minus one.
    logic [COL_BITS-1:0]  r_w_m1;
    logic [ROW_BITS-1:0]  r_h_m1;
    logic [CHAN_BITS-1:0] r_c_m1;
    logic [WIN_BITS-1:0]  r_ww_m1;
    logic [WIN_BITS-1:0]  r_wh_m1;

    // Stream position.
    logic [COL_BITS-1:0]  r_col,  n_col;
    logic [ROW_BITS-1:0]  r_row,  n_row;
    logic [CHAN_BITS-1:0] r_chan, n_chan;
    logic [WIN_BITS-1:0]  r_cin,  n_cin;
    logic [WIN_BITS-1:0]  r_rin,  n_rin;
    logic [COL_BITS-1:0]  r_ocol, n_ocol;
    logic [ROW_BITS-1:0]  r_orow, n_orow;

    // Update stage.
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [ADDR_BITS-1:0]          r_s1_addr;
    logic                          r_s1_load;
    logic                          r_s1_emit;
    logic                          r_s1_end;
    logic [COL_BITS-1:0]           r_s1_ocol;
    logic [ROW_BITS-1:0]           r_s1_orow;
    logic [CHAN_BITS-1:0]          r_s1_chan;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_pooled;
    logic [COL_BITS-1:0]           r_out_col;
    logic [ROW_BITS-1:0]           r_out_row;
    logic [CHAN_BITS-1:0]          r_out_chan;
    logic                          r_out_done;

    logic                          in_xfer;
    logic                          cfg_xfer;
    logic                          s1_adv;
    logic                          last_chan, col_end, row_end, last_col, last_row;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic signed [SAMPLE_BITS-1:0] stored;
    logic signed [SAMPLE_BITS-1:0] merged;

    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;

    // The update stage moves on unless its result would collide with a held one.
    assign s1_adv   = r_s1_valid && (!r_s1_emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_xfer  = i_in.valid && i_in.ready;

    // Window and image boundaries at the current position.
    assign last_chan = (r_chan == r_c_m1);
    assign col_end   = (r_col == r_w_m1);
    assign row_end   = (r_row == r_h_m1);
    assign last_col  = (r_cin == r_ww_m1) || col_end;
    assign last_row  = (r_rin == r_wh_m1) || row_end;
    assign rd_addr   = ADDR_BITS'(32'(r_ocol) * 32'(MAX_CHANNELS) + 32'(r_chan));

    // Next stream position after one sample transfer.
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        n_cin  = r_cin;
        n_rin  = r_rin;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (!last_chan) begin
            n_chan = r_chan + 1'b1;
        end else begin
            n_chan = '0;
            if (!col_end) begin
                n_col = r_col + 1'b1;
                if (last_col) begin
                    n_cin  = '0;
                    n_ocol = r_ocol + 1'b1;
                end else begin
                    n_cin = r_cin + 1'b1;
                end
            end else begin
                n_col  = '0;
                n_cin  = '0;
                n_ocol = '0;
                if (!row_end) begin
                    n_row = r_row + 1'b1;
                    if (last_row) begin
                        n_rin  = '0;
                        n_orow = r_orow + 1'b1;
                    end else begin
                        n_rin = r_rin + 1'b1;
                    end
                end else begin
                    n_row  = '0;
                    n_rin  = '0;
                    n_orow = '0;
                end
            end
        end
    end

    // Registers and stream position; a write to a defined register restarts the image.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1  <= '0;
            r_h_m1  <= '0;
            r_c_m1  <= '0;
            r_ww_m1 <= WIN_BITS'(WIN_RST);
            r_wh_m1 <= WIN_BITS'(WIN_RST);
            r_col   <= '0;
            r_row   <= '0;
            r_chan  <= '0;
            r_cin   <= '0;
            r_rin   <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
        end else if (cfg_xfer) begin
            case (mpws_pkg::t_cfg_reg'(i_cfg.index))
                mpws_pkg::CFG_IMAGE_WIDTH: begin
                    r_w_m1 <= COL_BITS'(mpws_pkg::clamp_m1(
                        32'(i_cfg.data[mpws_pkg::IMAGE_WIDTH_BITS-1:0]), MAX_WIDTH));
                end
                mpws_pkg::CFG_IMAGE_HEIGHT: begin
                    r_h_m1 <= ROW_BITS'(mpws_pkg::clamp_m1(
                        32'(i_cfg.data[mpws_pkg::IMAGE_HEIGHT_BITS-1:0]), MAX_HEIGHT));
                end
                mpws_pkg::CFG_CHANNEL_COUNT: begin
                    r_c_m1 <= CHAN_BITS'(mpws_pkg::clamp_m1(
                        32'(i_cfg.data[mpws_pkg::CHANNEL_COUNT_BITS-1:0]), MAX_CHANNELS));
                end
                mpws_pkg::CFG_WINDOW_WIDTH: begin
                    r_ww_m1 <= WIN_BITS'(mpws_pkg::clamp_m1(
                        32'(i_cfg.data[mpws_pkg::WINDOW_WIDTH_BITS-1:0]), MAX_WINDOW));
                end
                mpws_pkg::CFG_WINDOW_HEIGHT: begin
                    r_wh_m1 <= WIN_BITS'(mpws_pkg::clamp_m1(
                        32'(i_cfg.data[mpws_pkg::WINDOW_HEIGHT_BITS-1:0]), MAX_WINDOW));
                end
                default: begin
                end
            endcase
            if (i_cfg.index <= mpws_pkg::CFG_WINDOW_HEIGHT) begin
                r_col  <= '0;
                r_row  <= '0;
                r_chan <= '0;
                r_cin  <= '0;
                r_rin  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end
        end else if (in_xfer) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
            r_cin  <= n_cin;
            r_rin  <= n_rin;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // Update stage: sample and window flags wait here for the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_s1_sample <= i_in.sample;
            r_s1_addr   <= rd_addr;
            r_s1_load   <= (r_cin == '0) && (r_rin == '0);
            r_s1_emit   <= last_col && last_row;
            r_s1_end    <= col_end && row_end && last_chan;
            r_s1_ocol   <= r_ocol;
            r_s1_orow   <= r_orow;
            r_s1_chan   <= r_chan;
        end
    end

    mpws_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (merged),
        .o_rd_data (stored)
    );

    // The first sample of a window loads the entry; later ones keep the larger value.
    assign merged = (r_s1_load || (r_s1_sample > stored)) ? r_s1_sample : stored;

    // Output register; it takes a result while the previous one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && r_s1_emit) begin
            r_out_pooled <= merged;
            r_out_col    <= r_s1_ocol;
            r_out_row    <= r_s1_orow;
            r_out_chan   <= r_s1_chan;
            r_out_done   <= r_s1_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pooled     = r_out_pooled;
    assign o_out.out_col    = r_out_col;
    assign o_out.out_row    = r_out_row;
    assign o_out.channel    = r_out_chan;
    assign o_out.image_done = r_out_done;

    // The input side never blocks while the update stage is empty.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("sample channel stalled with an empty update stage");

    // The stream position stays inside the configured image and window.
    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_w_m1) && (r_row <= r_h_m1) && (r_chan <= r_c_m1)
        && (r_cin <= r_ww_m1) && (r_rin <= r_wh_m1))
        else $error("stream position outside the configured geometry");

    // The last result of an image belongs to the last channel.
    a_done_on_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.image_done) |-> (o_out.channel == r_c_m1))
        else $error("image end flagged on a result that is not the last channel");

    // A sample transfer always lands in the update stage.
    a_xfer_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_valid)
        else $error("accepted sample lost before the update stage");

endmodule

// ===== rtl/mpws_store.sv =====
// Running-maximum store: one entry per output column and channel.
// Registered read with forwarding of a write made in the cycle of the read.
// Standalone; used by max_pool_window_stream_top.
module mpws_store #(
    parameter int DEPTH       = 8192,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [ADDR_BITS-1:0]          i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [ADDR_BITS-1:0]          i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_data,
    output logic signed [SAMPLE_BITS-1:0] o_rd_data
);

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_fwd_data;
    logic                          r_fwd_hit;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    // A write to the same entry in the read cycle supersedes the memory data.
    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

// ===== tb/sv/tb_max_pool_window_stream_top.sv =====
// Testbench for max_pool_window_stream_top: drives samples and register writes, and
// checks every pooled result against a cycle-free model of the pooling held in the bench.
// Depends on mpws_pkg, the mpws_*_if interfaces and the top-level RTL.
`timescale 1ns / 100ps

module tb_max_pool_window_stream_top;

    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = mpws_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = mpws_pkg::CFG_DATA_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;

    // Indexes past the last defined register are decoded as nothing.
    localparam int FIRST_STRAY_INDEX = int'(mpws_pkg::CFG_WINDOW_HEIGHT) + 1;
    localparam int LAST_STRAY_INDEX  = (1 << CFG_INDEX_BITS) - 1;

    // The pause before a register write lets the update stage and output register drain.
    localparam int DRAIN_CYCLES   = 4;
    localparam int IDLE_LIMIT     = 2000;
    localparam int REPORT_CAP     = 100;
    localparam int RANDOM_SAMPLES = 1750;
    localparam int STEADY_SAMPLES = 200;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] pooled;
        logic [8:0]                    out_col;
        logic [8:0]                    out_row;
        logic [3:0]                    channel;
        logic                          image_done;
    } t_pool_result;

    typedef struct {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_reg_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpws_cfg_if                                cfg_bus ();
    mpws_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
    mpws_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) pool_bus ();

    max_pool_window_stream_top #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (sample_bus),
        .o_out  (pool_bus)
    );

    always #5 i_clk = ~i_clk;

    // Pooling model state: raw register contents, stream position and running maxima.
    logic [9:0] reg_image_w, reg_image_h;
    logic [4:0] reg_chans, reg_win_w, reg_win_h;
    int unsigned pos_col, pos_row, pos_chan;
    int unsigned win_col, win_row;
    int unsigned pool_col, pool_row;
    logic signed [SAMPLE_BITS-1:0] running_max [STORE_DEPTH];

    t_pool_result expected_pools [$];
    t_reg_write   pending_writes [$];
    int unsigned  samples_sent = 0;
    int unsigned  fail_count = 0;
    bit           bursts_on = 1'b1;
    int unsigned  stall_left = 0;
    int unsigned  idle_cycles = 0;

    // Zero acts as one, and anything past the limit acts as the limit.
    function automatic int unsigned effective(input int unsigned value, input int unsigned limit);
        if (value == 0) begin
            return 1;
        end
        return (value > limit) ? limit : value;
    endfunction

    function automatic void restart_stream();
        pos_col  = 0;
        pos_row  = 0;
        pos_chan = 0;
        win_col  = 0;
        win_row  = 0;
        pool_col = 0;
        pool_row = 0;
    endfunction

    function automatic void reset_settings();
        reg_image_w = 10'd1;
        reg_image_h = 10'd1;
        reg_chans   = 5'd1;
        reg_win_w   = 5'd2;
        reg_win_h   = 5'd2;
        restart_stream();
    endfunction

    // A defined register write lands in its field and sends the stream to the image start.
    function automatic void apply_setting(input logic [CFG_INDEX_BITS-1:0] index,
                                          input logic [CFG_DATA_BITS-1:0] data);
        case (index)
            mpws_pkg::CFG_IMAGE_WIDTH:
                reg_image_w = data[mpws_pkg::IMAGE_WIDTH_BITS-1:0];
            mpws_pkg::CFG_IMAGE_HEIGHT:
                reg_image_h = data[mpws_pkg::IMAGE_HEIGHT_BITS-1:0];
            mpws_pkg::CFG_CHANNEL_COUNT:
                reg_chans   = data[mpws_pkg::CHANNEL_COUNT_BITS-1:0];
            mpws_pkg::CFG_WINDOW_WIDTH:
                reg_win_w   = data[mpws_pkg::WINDOW_WIDTH_BITS-1:0];
            mpws_pkg::CFG_WINDOW_HEIGHT:
                reg_win_h   = data[mpws_pkg::WINDOW_HEIGHT_BITS-1:0];
            default:
                return;
        endcase
        restart_stream();
    endfunction

    // Folds one sample into its window and queues the pooled value when the window closes.
    function automatic void pool_sample(input logic signed [SAMPLE_BITS-1:0] value);
        int unsigned  cols, rows, chans, win_w, win_h, slot;
        bit           last_col, last_row, last_chan, image_end;
        t_pool_result rec;
        cols  = effective(reg_image_w, MAX_WIDTH);
        rows  = effective(reg_image_h, MAX_HEIGHT);
        chans = effective(reg_chans, MAX_CHANNELS);
        win_w = effective(reg_win_w, MAX_WINDOW);
        win_h = effective(reg_win_h, MAX_WINDOW);
        slot  = (pool_col * MAX_CHANNELS + pos_chan) % STORE_DEPTH;
        last_col  = (win_col + 1 >= win_w) || (pos_col + 1 >= cols);
        last_row  = (win_row + 1 >= win_h) || (pos_row + 1 >= rows);
        last_chan = (pos_chan + 1 >= chans);
        image_end = (pos_col + 1 >= cols) && (pos_row + 1 >= rows) && last_chan;

        if (win_col == 0 && win_row == 0) begin
            running_max[slot] = value;
        end else if (value > running_max[slot]) begin
            running_max[slot] = value;
        end

        if (last_col && last_row) begin
            rec.pooled     = running_max[slot];
            rec.out_col    = pool_col[8:0];
            rec.out_row    = pool_row[8:0];
            rec.channel    = pos_chan[3:0];
            rec.image_done = image_end;
            expected_pools.push_back(rec);
        end

        // Advance channel, then column, then row, then wrap to the next image.
        if (!last_chan) begin
            pos_chan++;
            return;
        end
        pos_chan = 0;
        if (pos_col + 1 < cols) begin
            pos_col++;
            if (last_col) begin
                win_col = 0;
                pool_col++;
            end else begin
                win_col++;
            end
            return;
        end
        pos_col  = 0;
        win_col  = 0;
        pool_col = 0;
        if (pos_row + 1 < rows) begin
            pos_row++;
            if (last_row) begin
                win_row = 0;
                pool_row++;
            end else begin
                win_row++;
            end
            return;
        end
        restart_stream();
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Image dimensions for the random shapes stay small; zero shows up now and then.
    function automatic logic [9:0] pick_image_dim();
        return ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 5));
    endfunction

    // Five-bit fields: mostly small, sometimes zero or at or past the limit, and sometimes
    // with junk in the data bits above the field.
    function automatic logic [9:0] pick_short_field(input int unsigned typical_hi);
        logic [4:0] val;
        case ($urandom_range(0, 7))
            0:       val = 5'd0;
            1:       val = 5'($urandom_range(16, 31));
            default: val = 5'($urandom_range(1, typical_hi));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            return {5'($urandom), val};
        end
        return {5'd0, val};
    endfunction

    function automatic int unsigned image_samples(input logic [9:0] w, input logic [9:0] h,
                                                  input logic [9:0] c);
        return effective(w, MAX_WIDTH) * effective(h, MAX_HEIGHT) *
               effective(c[4:0], MAX_CHANNELS);
    endfunction

    function automatic void queue_write(input logic [CFG_INDEX_BITS-1:0] index,
                                        input logic [CFG_DATA_BITS-1:0] data);
        t_reg_write wr;
        wr.index = index;
        wr.data  = data;
        pending_writes.push_back(wr);
    endfunction

    function automatic void configure(input logic [9:0] w, input logic [9:0] h,
                                      input logic [9:0] c, input logic [9:0] ww,
                                      input logic [9:0] wh);
        queue_write(mpws_pkg::CFG_IMAGE_WIDTH, w);
        queue_write(mpws_pkg::CFG_IMAGE_HEIGHT, h);
        queue_write(mpws_pkg::CFG_CHANNEL_COUNT, c);
        queue_write(mpws_pkg::CFG_WINDOW_WIDTH, ww);
        queue_write(mpws_pkg::CFG_WINDOW_HEIGHT, wh);
    endfunction

    function automatic void queue_stray_write();
        queue_write(CFG_INDEX_BITS'($urandom_range(FIRST_STRAY_INDEX, LAST_STRAY_INDEX)),
                    CFG_DATA_BITS'($urandom));
    endfunction

    // Called at a falling edge. Waits for the block to go idle, then performs every
    // queued register write back to back, holding valid high across them.
    task automatic flush_writes();
        t_reg_write wr;
        sample_bus.valid <= 1'b0;
        while (expected_pools.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (pending_writes.size() != 0) begin
            wr = pending_writes.pop_front();
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= wr.index;
            cfg_bus.data  <= wr.data;
            @(posedge i_clk);
            while (!cfg_bus.ready) @(posedge i_clk);
            apply_setting(wr.index, wr.data);
            @(negedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Called at a falling edge. Valid stays high after the transfer so that the next
    // sample can follow without a bubble; it drops only for a gap or a register write.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= value;
        @(posedge i_clk);
        while (!sample_bus.ready) @(posedge i_clk);
        pool_sample(value);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Register defaults after reset: 1x1 image, one channel, so every sample closes an image.
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(-16'sd1);
    endtask

    // 3x3 image, two channels, 2x2 window: full, right-cut, bottom-cut and corner windows.
    task automatic test_edge_windows();
        configure(10'd3, 10'd3, 10'd2, 10'd2, 10'd2);
        flush_writes();
        for (int k = 0; k < 18; k++) begin
            case (k % 4)
                0:       send_sample(SAMPLE_MIN);
                1:       send_sample(SAMPLE_MAX - SAMPLE_BITS'(k));
                2:       send_sample(-16'sd1);
                default: send_sample(SAMPLE_BITS'(k) - 16'sd9);
            endcase
        end
    endtask

    // Zero and oversized register values, a write to an unused index, and a restart
    // caused by a plain register write in the middle of an image.
    task automatic test_register_limits();
        configure(10'd0, 10'h3ff, 10'd0, 10'd31, 10'd0);
        flush_writes();
        repeat (3) send_sample(random_sample());
        queue_stray_write();
        flush_writes();
        repeat (2) send_sample(random_sample());
        queue_write(mpws_pkg::CFG_WINDOW_HEIGHT, 10'd1);
        flush_writes();
        repeat (2) send_sample(random_sample());
    endtask

    // Widest row (oversized width acts as the limit) and tallest column, one result
    // per sample, so the output column and row reach their top values.
    task automatic test_extreme_geometry();
        configure(10'h3ff, 10'd1, 10'd1, 10'd1, 10'd1);
        flush_writes();
        repeat (MAX_WIDTH) send_sample(random_sample());
        configure(10'd1, 10'(MAX_HEIGHT), 10'd1, 10'd1, 10'd1);
        flush_writes();
        repeat (MAX_HEIGHT) send_sample(random_sample());
    endtask

    // Random shapes: whole images, then maybe a cut-off tail that the next write restarts.
    task automatic test_random_shapes(input int unsigned goal);
        logic [9:0]  w, h, c, ww, wh;
        int unsigned per_image, count;
        while (samples_sent < goal) begin
            w  = pick_image_dim();
            h  = pick_image_dim();
            c  = pick_short_field(4);
            ww = pick_short_field(6);
            wh = pick_short_field(6);
            configure(w, h, c, ww, wh);
            if ($urandom_range(0, 5) == 0) begin
                queue_stray_write();
            end
            flush_writes();
            per_image = image_samples(w, h, c);
            if (per_image > 200) begin
                count = per_image;
            end else begin
                count = per_image * $urandom_range(1, 2) + $urandom_range(0, per_image - 1);
            end
            repeat (count) send_sample(random_sample());
        end
    endtask

    // Last stretch with random sample gaps and result stall bursts turned off.
    task automatic test_steady_stream();
        bursts_on = 1'b0;
        test_random_shapes(samples_sent + STEADY_SAMPLES);
    endtask

    // Result side: ready drops for random stall bursts while bursts are enabled.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pool_bus.ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            pool_bus.ready <= 1'b0;
        end else begin
            pool_bus.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endtask

    // Every result transfer is matched against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_pool_result want;
        if (i_rst_n && pool_bus.valid && pool_bus.ready) begin
            if (expected_pools.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP) begin
                    $error("pooled result with none expected: pooled %0d col %0d row %0d",
                           pool_bus.pooled, pool_bus.out_col, pool_bus.out_row);
                end
            end else begin
                want = expected_pools.pop_front();
                check_field("pooled", want.pooled, pool_bus.pooled);
                check_field("out_col", want.out_col, pool_bus.out_col);
                check_field("out_row", want.out_row, pool_bus.out_row);
                check_field("channel", want.channel, pool_bus.channel);
                check_field("image_done", want.image_done, pool_bus.image_done);
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_bus.valid && sample_bus.ready) ||
            (pool_bus.valid && pool_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        pool_bus.ready    = 1'b0;
        reset_settings();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_edge_windows();
        test_register_limits();
        test_extreme_geometry();
        test_random_shapes(RANDOM_SAMPLES);
        test_steady_stream();

        // Drain the remaining results, then allow for the output pipeline.
        sample_bus.valid <= 1'b0;
        while (expected_pools.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
